// ----- hw/rtl/pfg_pkg.sv -----
// ----------------------------------------------------------------------------
// Particle force generator package
// Shared widths, stage counts, codes and pipeline payload types.
// ----------------------------------------------------------------------------
package pfg_pkg;

    // Difference vector components are 33-bit two's complement.
    localparam int DW        = 33;
    // Vector length (floor square root of a 66-bit sum of squares).
    localparam int LW        = 34;
    // Radicand, padded to an even number of bits.
    localparam int RADW      = 68;
    // Partial remainder of the square root recurrence.
    localparam int REMW      = 36;
    localparam int SQ_STEPS  = LW;
    // Divider operands and quotient (one integer bit plus 32 fraction bits).
    localparam int NW        = 34;
    localparam int QW        = 33;
    localparam int DIV_STEPS = QW;
    // Magnitude stages that run beside the divider, and the delay that
    // lines their result up with the quotients.
    localparam int M_STAGES  = 5;
    localparam int DLY       = DIV_STEPS - M_STAGES;

    localparam logic [32:0] MAG_CAP = 33'h1_0000_0000;
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] NEG_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        OP_DRAG     = 2'd0,
        OP_SPRING   = 2'd1,
        OP_BUNGEE   = 2'd2,
        OP_BUOYANCY = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        CFG_DRAG_LINEAR      = 3'd0,
        CFG_DRAG_QUADRATIC   = 3'd1,
        CFG_SPRING_STIFFNESS = 3'd2,
        CFG_REST_LENGTH      = 3'd3,
        CFG_HALF_HEIGHT      = 3'd4,
        CFG_OBJECT_VOLUME    = 3'd5,
        CFG_SURFACE_LEVEL    = 3'd6,
        CFG_FLUID_DENSITY    = 3'd7
    } cfg_index_t;

    // Payload that travels with an item up to the end of the square root.
    typedef struct packed {
        logic          valid;
        op_t           op;
        logic [DW-1:0] dx;
        logic [DW-1:0] dy;
        logic [DW-1:0] dz;
        logic          dry;
        logic          sunk;
        logic [31:0]   num;
    } side_t;

    // Flags carried through the magnitude stages.
    typedef struct packed {
        logic       valid;
        op_t        op;
        logic [2:0] dneg;
        logic       dry;
        logic       sunk;
        logic       len_zero;
        logic       slack;
        logic       epos;
    } flags_t;

    // Force magnitude and control, waiting for the direction quotients.
    typedef struct packed {
        logic        valid;
        op_t         op;
        logic [2:0]  dneg;
        logic        applied;
        logic        zero_force;
        logic        neg_m;
        logic [32:0] mm;
        logic        sunk;
        logic [45:0] p;
    } mag_t;

endpackage

// ----- hw/rtl/pfg_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined fraction divider
// Computes floor(num * 2^32 / den) for num <= den, one quotient bit a stage.
// ----------------------------------------------------------------------------
module pfg_div import pfg_pkg::*; (
    input  logic          aclk,
    input  logic          en,
    input  logic [NW-1:0] num_in,
    input  logic [NW-1:0] den_in,
    output logic [QW-1:0] quo_out
);

    logic [NW-1:0] rem_reg [0:DIV_STEPS-1];
    logic [NW-1:0] den_reg [0:DIV_STEPS-1];
    logic [QW-1:0] quo_reg [0:DIV_STEPS-1];

    logic ge0;

    assign ge0 = (num_in >= den_in);

    // The first stage yields the integer bit, which is one only when num equals den.
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= ge0 ? NW'(num_in - den_in) : num_in;
            den_reg[0] <= den_in;
            quo_reg[0] <= {{(QW-1){1'b0}}, ge0};
        end
    end

    for (genvar g = 1; g < DIV_STEPS; g++) begin : g_step
        logic [NW:0] rt;
        logic        ge;

        always_comb begin
            rt = {rem_reg[g-1], 1'b0};
            ge = (rt >= {1'b0, den_reg[g-1]});
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g] <= ge ? NW'(rt - {1'b0, den_reg[g-1]}) : NW'(rt);
                den_reg[g] <= den_reg[g-1];
                quo_reg[g] <= {quo_reg[g-1][QW-2:0], ge};
            end
        end
    end

    assign quo_out = quo_reg[DIV_STEPS-1];

endmodule

// ----- hw/rtl/particle_force_generator.sv -----
// ----------------------------------------------------------------------------
// Particle force generator
// Drag, spring, bungee and buoyancy forces in Q16.16, one item per cycle when not stalled.
//
//   channel  direction  handshake          payload
//   s_       in         s_valid/s_ready    opcode, pos, vel, other
//   m_       out        m_valid/m_ready    force_x/y/z, applied
//   cfg_     in         cfg_wr_en          cfg_index, cfg_wdata
//
// A new item can enter every cycle while no result waits at the output.
// Each item passes the 34-stage square root and the 33-stage dividers.
// Reset clears the valid bits and loads the register defaults.
// When a result waits at the output, the whole pipeline holds in place.
// ----------------------------------------------------------------------------
module particle_force_generator import pfg_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_opcode,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic signed [31:0] s_pos_z,
    input  logic signed [31:0] s_vel_x,
    input  logic signed [31:0] s_vel_y,
    input  logic signed [31:0] s_vel_z,
    input  logic signed [31:0] s_other_x,
    input  logic signed [31:0] s_other_y,
    input  logic signed [31:0] s_other_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_force_x,
    output logic signed [31:0] m_force_y,
    output logic signed [31:0] m_force_z,
    output logic               m_applied
);

    function automatic logic [32:0] mag33(input logic [32:0] v);
        mag33 = v[32] ? (~v + 33'd1) : v;
    endfunction

    function automatic logic [32:0] sat_cap49(input logic [48:0] v);
        sat_cap49 = (v > 49'(MAG_CAP)) ? MAG_CAP : v[32:0];
    endfunction

    function automatic logic [31:0] sat_force(input logic [33:0] q, input logic neg);
        logic [33:0] nq;
        nq = ~q + 34'd1;
        if (!neg) begin
            sat_force = (q > 34'(POS_MAX)) ? POS_MAX : q[31:0];
        end else begin
            sat_force = (q > 34'(NEG_MIN)) ? NEG_MIN : nq[31:0];
        end
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [30:0] drag_linear_reg;
    logic [30:0] drag_quadratic_reg;
    logic [30:0] spring_stiffness_reg;
    logic [30:0] rest_length_reg;
    logic [30:0] half_height_reg;
    logic [30:0] object_volume_reg;
    logic [31:0] surface_level_reg;
    logic [30:0] fluid_density_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drag_linear_reg      <= '0;
            drag_quadratic_reg   <= '0;
            spring_stiffness_reg <= '0;
            rest_length_reg      <= '0;
            half_height_reg      <= 31'd65536;
            object_volume_reg    <= '0;
            surface_level_reg    <= '0;
            fluid_density_reg    <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_DRAG_LINEAR:      drag_linear_reg      <= cfg_wdata[30:0];
                CFG_DRAG_QUADRATIC:   drag_quadratic_reg   <= cfg_wdata[30:0];
                CFG_SPRING_STIFFNESS: spring_stiffness_reg <= cfg_wdata[30:0];
                CFG_REST_LENGTH:      rest_length_reg      <= cfg_wdata[30:0];
                CFG_HALF_HEIGHT:      half_height_reg      <= cfg_wdata[30:0];
                CFG_OBJECT_VOLUME:    object_volume_reg    <= cfg_wdata[30:0];
                CFG_SURFACE_LEVEL:    surface_level_reg    <= cfg_wdata;
                CFG_FLUID_DENSITY:    fluid_density_reg    <= cfg_wdata[30:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline advance: every stage moves when the output slot is free.
    // ------------------------------------------------------------------
    logic m_valid_reg;
    logic adv;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // ------------------------------------------------------------------
    // Stage 1: difference vector (velocity for drag) and buoyancy range checks
    // ------------------------------------------------------------------
    side_t       s1_next;
    side_t       s1_reg;
    logic [33:0] y34;
    logic [33:0] h34;
    logic [33:0] lvl34;

    always_comb begin
        y34   = {{2{s_pos_y[31]}}, s_pos_y};
        h34   = {3'b000, half_height_reg};
        lvl34 = {{2{surface_level_reg[31]}}, surface_level_reg};
        s1_next.valid = s_valid;
        s1_next.op    = op_t'(s_opcode);
        if (op_t'(s_opcode) == OP_DRAG) begin
            s1_next.dx = {s_vel_x[31], s_vel_x};
            s1_next.dy = {s_vel_y[31], s_vel_y};
            s1_next.dz = {s_vel_z[31], s_vel_z};
        end else begin
            s1_next.dx = {s_pos_x[31], s_pos_x} - {s_other_x[31], s_other_x};
            s1_next.dy = {s_pos_y[31], s_pos_y} - {s_other_y[31], s_other_y};
            s1_next.dz = {s_pos_z[31], s_pos_z} - {s_other_z[31], s_other_z};
        end
        s1_next.dry  = ($signed(y34 - h34) >= $signed(lvl34));
        s1_next.sunk = ($signed(y34 + h34) <= $signed(lvl34));
        s1_next.num  = 32'(lvl34 - y34 + h34);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_reg.valid <= 1'b0;
        end else if (adv) begin
            s1_reg <= s1_next;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: squared components
    // ------------------------------------------------------------------
    side_t       s2_reg;
    logic [65:0] sq_x_reg;
    logic [65:0] sq_y_reg;
    logic [65:0] sq_z_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_reg.valid <= 1'b0;
        end else if (adv) begin
            s2_reg   <= s1_reg;
            sq_x_reg <= mag33(s1_reg.dx) * mag33(s1_reg.dx);
            sq_y_reg <= mag33(s1_reg.dy) * mag33(s1_reg.dy);
            sq_z_reg <= mag33(s1_reg.dz) * mag33(s1_reg.dz);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3 and square root: one root bit per stage
    // ------------------------------------------------------------------
    logic [RADW-1:0] sq_rad_reg  [0:SQ_STEPS];
    logic [REMW-1:0] sq_rem_reg  [0:SQ_STEPS];
    logic [LW-1:0]   sq_root_reg [0:SQ_STEPS];
    side_t           sq_side_reg [0:SQ_STEPS];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_side_reg[0].valid <= 1'b0;
        end else if (adv) begin
            sq_side_reg[0] <= s2_reg;
            sq_rad_reg[0]  <= {2'b00, sq_x_reg + sq_y_reg + sq_z_reg};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
        end
    end

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        logic [REMW+1:0] rem_t;
        logic [REMW+1:0] trial;
        logic            take;

        always_comb begin
            rem_t = {sq_rem_reg[g], sq_rad_reg[g][RADW-1 -: 2]};
            trial = {2'b00, sq_root_reg[g], 2'b01};
            take  = (rem_t >= trial);
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                sq_side_reg[g+1].valid <= 1'b0;
            end else if (adv) begin
                sq_side_reg[g+1] <= sq_side_reg[g];
                sq_rad_reg[g+1]  <= {sq_rad_reg[g][RADW-3:0], 2'b00};
                sq_rem_reg[g+1]  <= take ? REMW'(rem_t - trial) : REMW'(rem_t);
                sq_root_reg[g+1] <= {sq_root_reg[g][LW-2:0], take};
            end
        end
    end

    logic [LW-1:0] len;
    side_t         sd;

    assign len = sq_root_reg[SQ_STEPS];
    assign sd  = sq_side_reg[SQ_STEPS];

    // ------------------------------------------------------------------
    // Direction dividers; lane x also forms the buoyancy depth ratio.
    // ------------------------------------------------------------------
    logic [NW-1:0] div_num_x;
    logic [NW-1:0] div_den_x;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    logic [QW-1:0] qz;

    always_comb begin
        if (sd.op == OP_BUOYANCY) begin
            div_num_x = {2'b00, sd.num};
            div_den_x = {2'b00, half_height_reg, 1'b0};
        end else begin
            div_num_x = {1'b0, mag33(sd.dx)};
            div_den_x = len;
        end
    end

    pfg_div u_div_x (
        .aclk    (aclk),
        .en      (adv),
        .num_in  (div_num_x),
        .den_in  (div_den_x),
        .quo_out (qx)
    );

    pfg_div u_div_y (
        .aclk    (aclk),
        .en      (adv),
        .num_in  ({1'b0, mag33(sd.dy)}),
        .den_in  (len),
        .quo_out (qy)
    );

    pfg_div u_div_z (
        .aclk    (aclk),
        .en      (adv),
        .num_in  ({1'b0, mag33(sd.dz)}),
        .den_in  (len),
        .quo_out (qz)
    );

    // ------------------------------------------------------------------
    // Magnitude stages M1..M5
    // ------------------------------------------------------------------
    flags_t      m1_f_next;
    logic [34:0] e35;
    flags_t      m1_f_reg;
    logic [64:0] m1_p1_reg;
    logic [67:0] m1_ll_reg;
    logic [33:0] m1_eabs_reg;
    logic [61:0] m1_pw_reg;

    always_comb begin
        e35 = {1'b0, len} - {4'b0000, rest_length_reg};
        m1_f_next.valid    = sd.valid;
        m1_f_next.op       = sd.op;
        m1_f_next.dneg     = {sd.dz[DW-1], sd.dy[DW-1], sd.dx[DW-1]};
        m1_f_next.dry      = sd.dry;
        m1_f_next.sunk     = sd.sunk;
        m1_f_next.len_zero = (len == '0);
        m1_f_next.slack    = (sd.op == OP_BUNGEE) && (len <= {3'b000, rest_length_reg});
        m1_f_next.epos     = !e35[34] && (e35 != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_f_reg.valid <= 1'b0;
        end else if (adv) begin
            m1_f_reg    <= m1_f_next;
            m1_p1_reg   <= drag_linear_reg * len;
            m1_ll_reg   <= len * len;
            m1_eabs_reg <= e35[34] ? 34'(~e35 + 35'd1) : e35[33:0];
            m1_pw_reg   <= fluid_density_reg * object_volume_reg;
        end
    end

    flags_t      m2_f_reg;
    logic [32:0] m2_c1_reg;
    logic [25:0] m2_l2h_reg;
    logic [25:0] m2_l2l_reg;
    logic [64:0] m2_pk_reg;
    logic [45:0] m2_p_reg;

    // The squared length is cut in two halves for the k2 product.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m2_f_reg.valid <= 1'b0;
        end else if (adv) begin
            m2_f_reg   <= m1_f_reg;
            m2_c1_reg  <= sat_cap49(m1_p1_reg[64:16]);
            m2_l2h_reg <= m1_ll_reg[67:42];
            m2_l2l_reg <= m1_ll_reg[41:16];
            m2_pk_reg  <= spring_stiffness_reg * m1_eabs_reg;
            m2_p_reg   <= m1_pw_reg[61:16];
        end
    end

    flags_t      m3_f_reg;
    logic [32:0] m3_c1_reg;
    logic [32:0] m3_ms_reg;
    logic [56:0] m3_c2h_reg;
    logic [56:0] m3_c2l_reg;
    logic [45:0] m3_p_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m3_f_reg.valid <= 1'b0;
        end else if (adv) begin
            m3_f_reg   <= m2_f_reg;
            m3_c1_reg  <= m2_c1_reg;
            m3_ms_reg  <= sat_cap49(m2_pk_reg[64:16]);
            m3_c2h_reg <= drag_quadratic_reg * m2_l2h_reg;
            m3_c2l_reg <= drag_quadratic_reg * m2_l2l_reg;
            m3_p_reg   <= m2_p_reg;
        end
    end

    flags_t      m4_f_reg;
    logic [32:0] m4_c1_reg;
    logic [32:0] m4_c2_reg;
    logic [32:0] m4_ms_reg;
    logic [45:0] m4_p_reg;
    logic [82:0] c2_sum;

    always_comb begin
        c2_sum = {m3_c2h_reg, 26'd0} + 83'(m3_c2l_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m4_f_reg.valid <= 1'b0;
        end else if (adv) begin
            m4_f_reg  <= m3_f_reg;
            m4_c1_reg <= m3_c1_reg;
            m4_c2_reg <= (c2_sum[82:16] > 67'(MAG_CAP)) ? MAG_CAP : c2_sum[48:16];
            m4_ms_reg <= m3_ms_reg;
            m4_p_reg  <= m3_p_reg;
        end
    end

    mag_t        m5_next;
    logic [33:0] c_sum;

    always_comb begin
        c_sum = {1'b0, m4_c1_reg} + {1'b0, m4_c2_reg};
        m5_next.valid = m4_f_reg.valid;
        m5_next.op    = m4_f_reg.op;
        m5_next.dneg  = m4_f_reg.dneg;
        m5_next.sunk  = m4_f_reg.sunk;
        m5_next.p     = m4_p_reg;
        if (m4_f_reg.op == OP_DRAG) begin
            m5_next.mm    = (c_sum > 34'(MAG_CAP)) ? MAG_CAP : c_sum[32:0];
            m5_next.neg_m = 1'b1;
        end else begin
            m5_next.mm    = m4_ms_reg;
            m5_next.neg_m = m4_f_reg.epos;
        end
        case (m4_f_reg.op)
            OP_BUOYANCY: m5_next.applied = !m4_f_reg.dry;
            OP_BUNGEE:   m5_next.applied = !m4_f_reg.slack;
            default:     m5_next.applied = 1'b1;
        endcase
        // A zero-length vector has no direction, so its force is zero.
        m5_next.zero_force = !m5_next.applied
                           || ((m4_f_reg.op != OP_BUOYANCY) && m4_f_reg.len_zero);
    end

    // ------------------------------------------------------------------
    // Delay line that lines the magnitude up with the quotients
    // ------------------------------------------------------------------
    mag_t dl_reg [0:DLY];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dl_reg[0].valid <= 1'b0;
        end else if (adv) begin
            dl_reg[0] <= m5_next;
        end
    end

    for (genvar g = 1; g <= DLY; g++) begin : g_dly
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dl_reg[g].valid <= 1'b0;
            end else if (adv) begin
                dl_reg[g] <= dl_reg[g-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // F1: unit direction times magnitude, buoyancy partial products
    // ------------------------------------------------------------------
    mag_t        f1_reg;
    logic [63:0] f1_px_reg;
    logic [63:0] f1_py_reg;
    logic [63:0] f1_pz_reg;
    logic [45:0] f1_bh_reg;
    logic [63:0] f1_bl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_reg.valid <= 1'b0;
        end else if (adv) begin
            f1_reg    <= dl_reg[DLY];
            f1_px_reg <= qx[QW-1:2] * dl_reg[DLY].mm;
            f1_py_reg <= qy[QW-1:2] * dl_reg[DLY].mm;
            f1_pz_reg <= qz[QW-1:2] * dl_reg[DLY].mm;
            f1_bh_reg <= dl_reg[DLY].p[45:32] * qx[31:0];
            f1_bl_reg <= dl_reg[DLY].p[31:0] * qx[31:0];
        end
    end

    // ------------------------------------------------------------------
    // F2: saturation and output register
    // ------------------------------------------------------------------
    logic [31:0] fx_next;
    logic [31:0] fy_next;
    logic [31:0] fz_next;
    logic [46:0] buoy_sum;
    logic [31:0] buoy_part;
    logic [31:0] buoy_full;
    logic [31:0] m_force_x_reg;
    logic [31:0] m_force_y_reg;
    logic [31:0] m_force_z_reg;
    logic        m_applied_reg;

    always_comb begin
        buoy_sum  = {1'b0, f1_bh_reg} + 47'(f1_bl_reg[63:32]);
        buoy_part = (buoy_sum > 47'(POS_MAX)) ? POS_MAX : buoy_sum[31:0];
        buoy_full = (f1_reg.p > 46'(POS_MAX)) ? POS_MAX : f1_reg.p[31:0];
        if (f1_reg.zero_force) begin
            fx_next = '0;
            fy_next = '0;
            fz_next = '0;
        end else if (f1_reg.op == OP_BUOYANCY) begin
            fx_next = '0;
            fy_next = f1_reg.sunk ? buoy_full : buoy_part;
            fz_next = '0;
        end else begin
            fx_next = sat_force(f1_px_reg[63:30], f1_reg.dneg[0] ^ f1_reg.neg_m);
            fy_next = sat_force(f1_py_reg[63:30], f1_reg.dneg[1] ^ f1_reg.neg_m);
            fz_next = sat_force(f1_pz_reg[63:30], f1_reg.dneg[2] ^ f1_reg.neg_m);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg   <= f1_reg.valid;
            m_force_x_reg <= fx_next;
            m_force_y_reg <= fy_next;
            m_force_z_reg <= fz_next;
            m_applied_reg <= f1_reg.applied;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_force_x = m_force_x_reg;
    assign m_force_y = m_force_y_reg;
    assign m_force_z = m_force_z_reg;
    assign m_applied = m_applied_reg;

`ifndef NO_ASSERTIONS
    // A force that does not apply leaves every component at zero.
    a_inactive_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_applied |-> (m_force_x == '0 && m_force_y == '0 && m_force_z == '0))
        else $error("inactive result carries a nonzero force");

    // Every input transfer lands in the first stage.
    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> s1_reg.valid)
        else $error("accepted item missing from first stage");

    // The magnitude never exceeds the Q16.16 cap.
    a_mag_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        dl_reg[0].valid |-> dl_reg[0].mm <= MAG_CAP)
        else $error("force magnitude above cap");

    // While the output is stalled, the last delay stage keeps its valid bit.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(dl_reg[DLY].valid))
        else $error("pipeline moved during a stall");
`endif

endmodule

// ----- sim/tb_top.sv -----
// ----------------------------------------------------------------------------
// Particle force generator testbench
// Drives drag, spring, bungee and buoyancy items through the block under
// bursty input and random output stalls, and checks every result against a
// fixed-point predictor of the four force kinds.
// ----------------------------------------------------------------------------
module tb_top;
    import pfg_pkg::*;

    typedef struct {
        op_t                op;
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic signed [31:0] oth [3];
    } particle_t;

    typedef struct {
        logic [31:0] f [3];
        logic        applied;
    } force_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [31:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [1:0]         s_opcode = '0;
    logic signed [31:0] s_pos_x = '0, s_pos_y = '0, s_pos_z = '0;
    logic signed [31:0] s_vel_x = '0, s_vel_y = '0, s_vel_z = '0;
    logic signed [31:0] s_other_x = '0, s_other_y = '0, s_other_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [31:0] m_force_x, m_force_y, m_force_z;
    logic               m_applied;

    // Register copies used by the predictor.
    logic [30:0]        k_lin, k_quad, k_spring, rest_len, half_h, volume, density;
    logic signed [31:0] surface;

    force_t      forces_due [$];
    int          mismatches = 0;
    int          cycles = 0;
    int          burst_left = 0;
    int          stall_pct = 0;
    int          gap_max = 4;

    particle_force_generator dut (.*);

    always #2 aclk = ~aclk;

    always @(negedge aclk) m_ready <= ($urandom_range(0, 99) >= stall_pct);

    function automatic logic [63:0] mag(input logic signed [63:0] x);
        return x < 0 ? -x : x;
    endfunction

    function automatic logic [63:0] mul_sat(input logic [63:0] a, input logic [63:0] b,
                                            input int s, input logic [63:0] cap);
        logic [127:0] p;
        p = ({64'b0, a} * {64'b0, b}) >> s;
        return (p > {64'b0, cap}) ? cap : p[63:0];
    endfunction

    function automatic logic [33:0] root_of(input logic [67:0] s);
        logic [33:0] r;
        logic [67:0] t;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            t = {34'b0, r | (34'd1 << b)};
            if (t * t <= s) r = r | (34'd1 << b);
        end
        return r;
    endfunction

    // One component of unit(d) scaled by a magnitude of sign neg_m and size mm.
    function automatic logic [31:0] dir_comp(input logic signed [63:0] di,
                                             input logic [33:0] len,
                                             input logic neg_m, input logic [63:0] mm);
        logic [127:0]       u;
        logic [127:0]       q;
        logic signed [63:0] v;
        u = {mag(di), 30'b0} / len;
        q = (u * mm) >> 30;
        v = ((di < 0) != neg_m) ? -$signed(q[63:0]) : $signed(q[63:0]);
        if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
        if (v < -64'sh8000_0000) v = -64'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic force_t compute_force(input particle_t it);
        force_t             r;
        logic signed [63:0] d [3];
        logic [67:0]        ss;
        logic [33:0]        len;
        logic [63:0]        c1, l2, c2, c, mm, p, rat;
        logic signed [63:0] e, y, h, surf, num;
        logic               neg_m;
        r.f = '{32'd0, 32'd0, 32'd0};
        r.applied = 1'b1;
        if (it.op == OP_BUOYANCY) begin
            y = 64'(it.pos[1]);
            h = {33'b0, half_h};
            surf = 64'(surface);
            p = ({33'b0, density} * {33'b0, volume}) >> 16;
            if (y - h >= surf) begin
                r.applied = 1'b0;
            end else if (y + h <= surf) begin
                r.f[1] = (p > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : p[31:0];
            end else begin
                num = surf - y + h;
                rat = 64'(({64'b0, num} << 32) / (2 * h));
                r.f[1] = 32'(mul_sat(p, rat, 32, 64'h7FFF_FFFF));
            end
            return r;
        end
        for (int i = 0; i < 3; i++) begin
            if (it.op == OP_DRAG) d[i] = 64'(it.vel[i]);
            else d[i] = 64'(it.pos[i]) - 64'(it.oth[i]);
        end
        ss = '0;
        for (int i = 0; i < 3; i++) ss = ss + {4'b0, mag(d[i])} * {4'b0, mag(d[i])};
        len = root_of(ss);
        if (it.op == OP_BUNGEE && len <= rest_len) begin
            r.applied = 1'b0;
            return r;
        end
        if (len == 0) return r;
        if (it.op == OP_DRAG) begin
            c1 = mul_sat({33'b0, k_lin}, {30'b0, len}, 16, 64'h1_0000_0000);
            l2 = mul_sat({30'b0, len}, {30'b0, len}, 16, '1);
            c2 = mul_sat({33'b0, k_quad}, l2, 16, 64'h1_0000_0000);
            c = c1 + c2;
            mm = (c > 64'h1_0000_0000) ? 64'h1_0000_0000 : c;
            neg_m = (mm != 0);
        end else begin
            e = $signed({30'b0, len}) - $signed({33'b0, rest_len});
            mm = mul_sat({33'b0, k_spring}, mag(e), 16, 64'h1_0000_0000);
            neg_m = (e > 0) && (mm != 0);
        end
        for (int i = 0; i < 3; i++) r.f[i] = dir_comp(d[i], len, neg_m, mm);
        return r;
    endfunction

    // Every accepted item queues its expected force; every result is checked.
    always @(posedge aclk) begin
        particle_t it;
        force_t    want;
        cycles <= cycles + 1;
        if (cycles > 600000) begin
            $display("end of test: mismatches");
            $finish;
        end
        if (aresetn && s_valid && s_ready) begin
            it.op = op_t'(s_opcode);
            it.pos = '{s_pos_x, s_pos_y, s_pos_z};
            it.vel = '{s_vel_x, s_vel_y, s_vel_z};
            it.oth = '{s_other_x, s_other_y, s_other_z};
            forces_due.push_back(compute_force(it));
        end
        if (aresetn && m_valid && m_ready) begin
            if (forces_due.size() == 0) begin
                $error("result transfer with nothing expected");
                mismatches++;
            end else begin
                want = forces_due.pop_front();
                if (m_force_x !== want.f[0]) begin
                    $error("force_x expected %h got %h", want.f[0], m_force_x);
                    mismatches++;
                end
                if (m_force_y !== want.f[1]) begin
                    $error("force_y expected %h got %h", want.f[1], m_force_y);
                    mismatches++;
                end
                if (m_force_z !== want.f[2]) begin
                    $error("force_z expected %h got %h", want.f[2], m_force_z);
                    mismatches++;
                end
                if (m_applied !== want.applied) begin
                    $error("applied expected %b got %b", want.applied, m_applied);
                    mismatches++;
                end
            end
        end
    end

    task automatic send_item(input particle_t it);
        @(negedge aclk);
        if (burst_left == 0) begin
            if (gap_max > 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, gap_max)) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 30);
        end
        s_valid   <= 1'b1;
        s_opcode  <= it.op;
        s_pos_x   <= it.pos[0];
        s_pos_y   <= it.pos[1];
        s_pos_z   <= it.pos[2];
        s_vel_x   <= it.vel[0];
        s_vel_y   <= it.vel[1];
        s_vel_z   <= it.vel[2];
        s_other_x <= it.oth[0];
        s_other_y <= it.oth[1];
        s_other_z <= it.oth[2];
        do @(posedge aclk); while (!s_ready);
        burst_left--;
    endtask

    // Lets the pipeline empty so registers can be rewritten safely.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (forces_due.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [31:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_DRAG_LINEAR:      k_lin = value[30:0];
            CFG_DRAG_QUADRATIC:   k_quad = value[30:0];
            CFG_SPRING_STIFFNESS: k_spring = value[30:0];
            CFG_REST_LENGTH:      rest_len = value[30:0];
            CFG_HALF_HEIGHT:      half_h = value[30:0];
            CFG_OBJECT_VOLUME:    volume = value[30:0];
            CFG_SURFACE_LEVEL:    surface = value;
            CFG_FLUID_DENSITY:    density = value[30:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [31:0] rand_val();
        case ($urandom_range(0, 5))
            0, 1: return $urandom;
            2: begin
                case ($urandom_range(0, 4))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'hFFFF_FFFF;
                    3: return 32'h0000_0001;
                    default: return 32'h0;
                endcase
            end
            3: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
            default: return 32'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000;
        endcase
    endfunction

    // Coefficient values: moderate half of the time, else zero, full scale or random.
    function automatic logic [31:0] rand_coef();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'h7FFF_FFFF;
            2: return {1'b0, 31'($urandom)};
            default: return 32'($urandom_range(1, 32'h0004_0000));
        endcase
    endfunction

    function automatic particle_t rand_item(input op_t op);
        particle_t it;
        it.op = op;
        for (int i = 0; i < 3; i++) begin
            it.pos[i] = rand_val();
            it.vel[i] = rand_val();
            it.oth[i] = rand_val();
        end
        // Keep the pair close often so spring lengths straddle the rest length.
        if (op != OP_DRAG && $urandom_range(0, 2) != 0)
            for (int i = 0; i < 3; i++)
                it.oth[i] = it.pos[i] + 32'($urandom_range(0, 32'h0006_0000)) - 32'h0003_0000;
        if (op == OP_DRAG && $urandom_range(0, 15) == 0) it.vel = '{32'd0, 32'd0, 32'd0};
        if (op == OP_BUOYANCY && $urandom_range(0, 3) != 0)
            it.pos[1] = surface + 32'($urandom_range(0, 3 * half_h))
                        - 32'($urandom_range(0, 3 * half_h));
        return it;
    endfunction

    function automatic particle_t make_item(input op_t op, input logic [31:0] a,
                                            input logic [31:0] b, input logic [31:0] c);
        particle_t it;
        it.op = op;
        it.pos = '{a, b, c};
        it.vel = '{a, b, c};
        it.oth = '{32'd0, 32'd0, 32'd0};
        return it;
    endfunction

    task automatic write_all_random();
        write_reg(CFG_DRAG_LINEAR, rand_coef());
        write_reg(CFG_DRAG_QUADRATIC, rand_coef());
        write_reg(CFG_SPRING_STIFFNESS, rand_coef());
        write_reg(CFG_REST_LENGTH, $urandom_range(0, 3) == 0 ? rand_coef()
                                   : 32'($urandom_range(0, 32'h0004_0000)));
        write_reg(CFG_HALF_HEIGHT, $urandom_range(0, 5) == 0 ? 32'h7FFF_FFFF
                                   : 32'($urandom_range(1, 32'h0004_0000)));
        write_reg(CFG_OBJECT_VOLUME, rand_coef());
        write_reg(CFG_SURFACE_LEVEL, $urandom_range(0, 3) == 0 ? rand_val()
                                     : 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000);
        write_reg(CFG_FLUID_DENSITY, rand_coef());
    endtask

    task automatic test_reset_defaults();
        send_item(make_item(OP_DRAG, 32'h0001_0000, 32'h0, 32'h0));
        send_item(make_item(OP_SPRING, 32'h0002_0000, 32'h0, 32'h0));
        send_item(make_item(OP_BUNGEE, 32'h0, 32'h0, 32'h0));
        send_item(make_item(OP_BUNGEE, 32'h0000_0001, 32'h0, 32'h0));
        send_item(make_item(OP_BUOYANCY, 32'h0, 32'h0, 32'h0));
        drain();
    endtask

    task automatic test_directed();
        particle_t it;
        write_reg(CFG_DRAG_LINEAR, 32'h7FFF_FFFF);
        write_reg(CFG_DRAG_QUADRATIC, 32'h7FFF_FFFF);
        write_reg(CFG_SPRING_STIFFNESS, 32'h7FFF_FFFF);
        write_reg(CFG_REST_LENGTH, 32'h0001_0000);
        write_reg(CFG_HALF_HEIGHT, 32'h0001_0000);
        write_reg(CFG_OBJECT_VOLUME, 32'h7FFF_FFFF);
        write_reg(CFG_SURFACE_LEVEL, 32'h0);
        write_reg(CFG_FLUID_DENSITY, 32'h7FFF_FFFF);
        // Zero-length vectors give zero force but still count as applied.
        send_item(make_item(OP_DRAG, 32'h0, 32'h0, 32'h0));
        send_item(make_item(OP_SPRING, 32'h0, 32'h0, 32'h0));
        send_item(make_item(OP_DRAG, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_item(make_item(OP_DRAG, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001));
        send_item(make_item(OP_DRAG, 32'h0000_0001, 32'h0, 32'hFFFF_FFFF));
        it = make_item(OP_SPRING, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        it.oth = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
        send_item(it);
        it.op = OP_BUNGEE;
        send_item(it);
        // Slack bungee, exactly at rest length and just beyond it.
        send_item(make_item(OP_BUNGEE, 32'h0000_8000, 32'h0, 32'h0));
        send_item(make_item(OP_BUNGEE, 32'h0001_0000, 32'h0, 32'h0));
        send_item(make_item(OP_BUNGEE, 32'h0001_0001, 32'h0, 32'h0));
        send_item(make_item(OP_SPRING, 32'h0, 32'h0000_8000, 32'h0));
        // Out of water, on the boundaries, submerged and partly submerged.
        send_item(make_item(OP_BUOYANCY, 32'h0, 32'h0001_0000, 32'h0));
        send_item(make_item(OP_BUOYANCY, 32'h0, 32'h7FFF_FFFF, 32'h0));
        send_item(make_item(OP_BUOYANCY, 32'h0, 32'hFFFF_0000, 32'h0));
        send_item(make_item(OP_BUOYANCY, 32'h0, 32'h8000_0000, 32'h0));
        send_item(make_item(OP_BUOYANCY, 32'h0, 32'h0000_8000, 32'h0));
        send_item(make_item(OP_BUOYANCY, 32'h0, 32'hFFFF_FFFF, 32'h0));
        drain();
        write_reg(CFG_HALF_HEIGHT, 32'h0000_0001);
        write_reg(CFG_SURFACE_LEVEL, 32'h8000_0000);
        write_reg(CFG_OBJECT_VOLUME, 32'h0003_0000);
        write_reg(CFG_FLUID_DENSITY, 32'h0002_0000);
        send_item(make_item(OP_BUOYANCY, 32'h0, 32'h8000_0000, 32'h0));
        send_item(make_item(OP_BUOYANCY, 32'h0, 32'h7FFF_FFFF, 32'h0));
        drain();
        write_reg(CFG_HALF_HEIGHT, 32'h7FFF_FFFF);
        write_reg(CFG_SURFACE_LEVEL, 32'h7FFF_FFFF);
        send_item(make_item(OP_BUOYANCY, 32'h0, 32'h8000_0000, 32'h0));
        send_item(make_item(OP_BUOYANCY, 32'h0, 32'h7FFF_FFFF, 32'h0));
        drain();
    endtask

    task automatic test_random_phase(input op_t op, input logic any_op, input int n,
                                     input int phases);
        for (int ph = 0; ph < phases; ph++) begin
            write_all_random();
            stall_pct = (ph % 3 == 0) ? 0 : $urandom_range(10, 70);
            gap_max = (ph % 4 == 1) ? 0 : $urandom_range(1, 8);
            for (int i = 0; i < n; i++)
                send_item(rand_item(any_op ? op_t'($urandom_range(0, 3)) : op));
            drain();
        end
    endtask

    initial begin
        k_lin = '0;
        k_quad = '0;
        k_spring = '0;
        rest_len = '0;
        half_h = 31'd65536;
        volume = '0;
        surface = '0;
        density = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_defaults();
        test_directed();
        test_random_phase(OP_DRAG, 1'b0, 50, 5);
        test_random_phase(OP_SPRING, 1'b0, 40, 4);
        test_random_phase(OP_BUNGEE, 1'b0, 40, 4);
        test_random_phase(OP_BUOYANCY, 1'b0, 50, 6);
        test_random_phase(OP_DRAG, 1'b1, 50, 8);
        repeat (100) @(negedge aclk);
        if (mismatches == 0 && forces_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/pfg_pkg.sv
hw/rtl/pfg_div.sv
hw/rtl/particle_force_generator.sv
sim/tb_top.sv
